FILE: rtl/vrm_pkg.sv
// vrm_pkg: shared constants and types of the voxel ray marcher.
// No dependencies; used by vrm_div and voxel_ray_marcher_unit.
`timescale 1ns / 1ps
`default_nettype none
package vrm_pkg;

    localparam int GRID_X_DEF    = 32;
    localparam int GRID_Y_DEF    = 32;
    localparam int GRID_Z_DEF    = 16;
    localparam int MAX_STEPS_DEF = 2048;

    localparam int POS_W   = 21;
    localparam int DIVN_W  = 27;
    localparam int DIVD_W  = 16;

    localparam logic [7:0] CLEAR_CODE = 8'd32;

    typedef enum logic [2:0] {
        CFG_STEP_EPS   = 3'd0,
        CFG_STEP_LIMIT = 3'd1,
        CFG_BORDER     = 3'd2,
        CFG_EMPTY      = 3'd3,
        CFG_EDGE       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] code;
        logic       hit;
        logic       timeout;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/vrm_cell_mem.sv
// vrm_cell_mem: single-port-write, registered-read store of cell codes.
// Depends on nothing; instantiated by voxel_ray_marcher_unit.
`timescale 1ns / 1ps
`default_nettype none
module vrm_cell_mem #(
    parameter int AW = 14
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);

    logic [7:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/vrm_div.sv
// vrm_div: restoring divider, one quotient bit per cycle.
// Depends on vrm_pkg; instantiated by voxel_ray_marcher_unit.
`timescale 1ns / 1ps
`default_nettype none
module vrm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [vrm_pkg::DIVN_W-1:0] dividend,
    input  wire logic [vrm_pkg::DIVD_W-1:0] divisor,
    output logic                            busy,
    output logic                            done,
    output logic [vrm_pkg::DIVN_W-1:0]      quotient
);

    localparam int CW = $clog2(vrm_pkg::DIVN_W);

    logic [vrm_pkg::DIVD_W-1:0] rem_reg;
    logic [vrm_pkg::DIVN_W-1:0] quo_reg;
    logic [vrm_pkg::DIVD_W-1:0] div_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [vrm_pkg::DIVD_W:0]   shifted;
    logic                       fits;

    assign shifted = {rem_reg, quo_reg[vrm_pkg::DIVN_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(vrm_pkg::DIVN_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? vrm_pkg::DIVD_W'(shifted - {1'b0, div_reg})
                            : shifted[vrm_pkg::DIVD_W-1:0];
            quo_reg <= {quo_reg[vrm_pkg::DIVN_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: rtl/voxel_ray_marcher_unit.sv
// voxel_ray_marcher_unit: top level, cast sequencer, config registers.
// Depends on vrm_pkg, vrm_cell_mem and vrm_div.
//
//  channel | handshake            | word
//  in      | in_valid / in_stall  | command, cell_*, origin_*, dir_*
//  out     | out_valid / out_stall| pixel_code, hit_flag, timed_out
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A cast step runs a bounds check, a store read, a select state per direction component
// and a multiply and an add per component, plus a wait on the shared divider for each
// component above threshold; up to MAX_STEPS+1 reads. After reset the store is cleared,
// one entry a cycle; no word is taken meanwhile. Config writes are always taken.
// A finished result is held in the output register while out_stall is high.
`timescale 1ns / 1ps
`default_nettype none
module voxel_ray_marcher_unit #(
    parameter int GRID_X    = vrm_pkg::GRID_X_DEF,
    parameter int GRID_Y    = vrm_pkg::GRID_Y_DEF,
    parameter int GRID_Z    = vrm_pkg::GRID_Z_DEF,
    parameter int MAX_STEPS = vrm_pkg::MAX_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    input  wire logic [4:0]         cell_x,
    input  wire logic [4:0]         cell_y,
    input  wire logic [3:0]         cell_z,
    input  wire logic [7:0]         cell_value,
    input  wire logic signed [17:0] origin_x,
    input  wire logic signed [17:0] origin_y,
    input  wire logic signed [17:0] origin_z,
    input  wire logic signed [15:0] dir_x,
    input  wire logic signed [15:0] dir_y,
    input  wire logic signed [15:0] dir_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              pixel_code,
    output logic                    hit_flag,
    output logic                    timed_out,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(GRID_Z);
    localparam int AW = XW + YW + ZW;
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int PW = vrm_pkg::POS_W;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_READ  = 9'b000001000,
        S_DSEL  = 9'b000010000,
        S_DWAIT = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_ADD   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] eps_reg;
    logic [15:0] limit_reg;
    logic [11:0] border_reg;
    logic [7:0]  empty_reg;
    logic [7:0]  edge_reg;

    logic signed [PW-1:0] p_reg [0:2];
    logic signed [15:0]   d_reg [0:2];
    logic [1:0]           comp_reg;
    logic [15:0]          dist_reg;
    logic [SW-1:0]        steps_reg;
    logic [AW-1:0]        clr_reg;
    logic signed [33:0]   prod_reg;
    vrm_pkg::result_t     pend_reg;
    vrm_pkg::result_t     res_reg;
    logic                 out_valid_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [vrm_pkg::DIVN_W-1:0] div_q;
    logic [vrm_pkg::DIVN_W-1:0] div_n;
    logic [vrm_pkg::DIVD_W-1:0] div_d;

    logic                 in_acc;
    logic                 wr_ok;
    logic                 outside;
    logic [1:0]           edge_cnt;
    logic signed [PW-1:0] p_cur;
    logic signed [16:0]   d_cur;
    logic signed [16:0]   thr;
    logic                 d_pos;
    logic                 d_neg;
    logic [12:0]          gap;
    logic [16:0]          adv;
    logic                 out_free;

    vrm_cell_mem #(.AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    vrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign wr_ok = (32'(cell_x) < GRID_X) && (32'(cell_y) < GRID_Y)
                   && (32'(cell_z) < GRID_Z);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = vrm_pkg::CLEAR_CODE;
        end
        else
        begin
            mem_we    = in_acc && !command && wr_ok;
            mem_waddr = {ZW'(cell_z), YW'(cell_y), XW'(cell_x)};
            mem_wdata = cell_value;
        end
    end

    assign mem_raddr = {p_reg[2][12 +: ZW], p_reg[1][12 +: YW], p_reg[0][12 +: XW]};

    always_comb
    begin
        outside = 1'b0;
        if (p_reg[0] < 0 || p_reg[0] >= PW'(GRID_X * 4096))
        begin
            outside = 1'b1;
        end
        if (p_reg[1] < 0 || p_reg[1] >= PW'(GRID_Y * 4096))
        begin
            outside = 1'b1;
        end
        if (p_reg[2] < 0 || p_reg[2] >= PW'(GRID_Z * 4096))
        begin
            outside = 1'b1;
        end
    end

    always_comb
    begin
        logic [11:0] fr;
        logic [12:0] dd;
        edge_cnt = '0;
        for (int i = 0; i < 3; i++)
        begin
            fr = p_reg[i][11:0];
            dd = fr[11] ? 13'd4096 - {1'b0, fr} : {1'b0, fr};
            if (dd < {1'b0, border_reg})
            begin
                edge_cnt = edge_cnt + 2'd1;
            end
        end
    end

    assign p_cur = p_reg[comp_reg];
    assign d_cur = 17'(d_reg[comp_reg]);
    assign thr   = $signed({3'b000, eps_reg, 2'b00});
    assign d_pos = d_cur > thr;
    assign d_neg = d_cur < -thr;
    assign gap   = d_pos ? 13'd4096 - {1'b0, p_cur[11:0]} : {1'b0, p_cur[11:0]};
    assign div_n = {gap, 14'd0};
    assign div_d = d_pos ? d_cur[15:0] : 16'(-d_cur);
    assign div_start = (state_reg == S_DSEL) && (d_pos || d_neg);
    assign adv   = {1'b0, dist_reg} + {5'd0, eps_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == '1) state_next = S_IDLE;
            S_IDLE:  if (in_acc && command) state_next = S_CHECK;
            S_CHECK: state_next = outside ? S_DONE : S_READ;
            S_READ:
            begin
                if (mem_rdata != empty_reg || 32'(steps_reg) >= MAX_STEPS)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DSEL;
                end
            end
            S_DSEL:
            begin
                if (d_pos || d_neg)
                begin
                    state_next = S_DWAIT;
                end
                else if (comp_reg == 2'd2)
                begin
                    state_next = S_MUL;
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (comp_reg == 2'd2) ? S_MUL : S_DSEL;
                end
            end
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = (comp_reg == 2'd2) ? S_CHECK : S_MUL;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            eps_reg       <= 12'd82;
            limit_reg     <= 16'd8192;
            border_reg    <= 12'd2048;
            empty_reg     <= 8'd32;
            edge_reg      <= 8'd46;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    vrm_pkg::CFG_STEP_EPS:   eps_reg    <= cfg_data[11:0];
                    vrm_pkg::CFG_STEP_LIMIT: limit_reg  <= cfg_data;
                    vrm_pkg::CFG_BORDER:     border_reg <= cfg_data[11:0];
                    vrm_pkg::CFG_EMPTY:      empty_reg  <= cfg_data[7:0];
                    vrm_pkg::CFG_EDGE:       edge_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                p_reg[0]  <= PW'(origin_x);
                p_reg[1]  <= PW'(origin_y);
                p_reg[2]  <= PW'(origin_z);
                d_reg[0]  <= dir_x;
                d_reg[1]  <= dir_y;
                d_reg[2]  <= dir_z;
                steps_reg <= '0;
            end
            S_CHECK:
            begin
                pend_reg <= '{code: empty_reg, hit: 1'b0, timeout: 1'b0};
            end
            S_READ:
            begin
                comp_reg <= 2'd0;
                dist_reg <= limit_reg;
                if (mem_rdata != empty_reg)
                begin
                    pend_reg <= '{code: (edge_cnt >= 2'd2) ? edge_reg : mem_rdata,
                                  hit: 1'b1, timeout: 1'b0};
                end
                else if (32'(steps_reg) >= MAX_STEPS)
                begin
                    pend_reg <= '{code: empty_reg, hit: 1'b0, timeout: 1'b1};
                end
            end
            S_DSEL:
            begin
                if (!(d_pos || d_neg))
                begin
                    comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                end
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    if (div_q < vrm_pkg::DIVN_W'(dist_reg))
                    begin
                        dist_reg <= div_q[15:0];
                    end
                    comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                end
            end
            S_MUL:
            begin
                prod_reg <= $signed({1'b0, adv}) * d_reg[comp_reg];
            end
            S_ADD:
            begin
                p_reg[comp_reg] <= p_cur + PW'($signed(prod_reg[33:14]));
                if (comp_reg == 2'd2)
                begin
                    comp_reg  <= 2'd0;
                    steps_reg <= steps_reg + 1'b1;
                end
                else
                begin
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_reg <= pend_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign pixel_code = res_reg.code;
    assign hit_flag   = res_reg.hit;
    assign timed_out  = res_reg.timeout;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall && !mem_we == 1'b0)
        else $error("clearing pass not writing or accepting words");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit_flag && timed_out))
        else $error("result both hit and timed out");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> out_valid)
        else $error("finished cast not presented");

endmodule
`default_nettype wire
